// ----- rtl/prefix_vector_distance_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the prefix vector distance unit
// Short forms for clocked assertions with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef PREFIX_VECTOR_DISTANCE_UNIT_MACROS_SVH
`define PREFIX_VECTOR_DISTANCE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PVD_ASSERT_IMM(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PVD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/pvd_pkg.sv -----
// ----------------------------------------------------------------------------
// Prefix vector distance package
// Widths, constants, state codes and shared types of the distance unit.
// ----------------------------------------------------------------------------
package pvd_pkg;

	localparam int ELEM_W   = 16;
	localparam int PREFIX_W = 13;
	localparam int DIST_W   = 24;
	localparam int DOT_W    = 44;
	localparam int NORM_W   = 43;
	localparam int DSQ_W    = 45;
	localparam int MUL_W    = 31;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int ROOT_W   = 30;
	localparam int RAD_W    = 2 * ROOT_W;
	localparam int DEN_W    = 60;
	localparam int NUM_W    = DOT_W + 32;
	localparam int QUO_W    = 25;
	localparam int CNT_W    = 7;

	localparam logic [PREFIX_W-1:0] MAX_DIM  = PREFIX_W'(4096);
	localparam logic [DIST_W-1:0]   DIST_MAX = {DIST_W{1'b1}};
	localparam logic [DIST_W-1:0]   ONE_Q16  = DIST_W'(65536);
	localparam logic [CNT_W-1:0]    MUL_LAST = CNT_W'(5);
	localparam logic [CNT_W-1:0]    SQ_LAST  = CNT_W'(ROOT_W - 1);
	localparam logic [CNT_W-1:0]    DIV_LAST = CNT_W'(NUM_W - 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_SQRT = 6'b000100,
		ST_NMUL = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		SQ_EUCL = 2'd0,
		SQ_NA   = 2'd1,
		SQ_NB   = 2'd2
	} sq_phase_t;

	// Request to the shared multiplier.
	typedef struct packed {
		logic                    en;
		logic signed [MUL_W-1:0] x;
		logic signed [MUL_W-1:0] y;
	} mul_req_t;

endpackage

// ----- rtl/pvd_mul.sv -----
// ----------------------------------------------------------------------------
// Shared registered multiplier
// Signed multiply with the product held in a register until the next request.
// ----------------------------------------------------------------------------
module pvd_mul import pvd_pkg::*; (
	input  logic                     clk,
	input  mul_req_t                 req,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	// The product only changes when a new request is issued.
	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= req.x * req.y;
		end
	end

	assign prod = prod_q;

endmodule

// ----- rtl/prefix_vector_distance_unit.sv -----
// ----------------------------------------------------------------------------
// Prefix vector distance unit
// Euclidean or cosine distance over a leading prefix of two streamed vectors.
// ----------------------------------------------------------------------------
//  Channel  Signals                           Payload
//  s_*      s_tvalid s_tready s_tdata s_tlast  element pair, prefix, last flag
//  m_*      m_tvalid m_tready m_tdata m_tuser  distance Q8.16, infinite flag
//  cfg_*    cfg_valid cfg_ready cfg_data       metric mode (0 L2, 1 cosine)
//
//  Every pair is transferred and then, in ST_MUL, the shared multiplier
//  forms four products and the accumulators take them.
//  On the last pair, Euclidean mode adds a bit-pair square root and
//  cosine mode adds two roots, one multiply and a 76-step long division;
//  a zero prefix, or a zero norm in cosine mode, goes straight to ST_FIN.
//  A finished result waits in the output register; input is taken meanwhile,
//  and a further result holds the unit in its final state until that frees.
//  Reset clears the accumulators, the index and the mode register.
// ----------------------------------------------------------------------------
`include "prefix_vector_distance_unit_macros.svh"

module prefix_vector_distance_unit import pvd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // a_elem[15:0], b_elem[31:16], prefix_len[44:32]
	input  logic        s_tlast,   // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // distance[23:0]
	output logic        m_tuser,   // infinite
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_data   // metric_mode
);

	state_t                    state_q;
	sq_phase_t                 phase_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      mode_q;
	logic signed [ELEM_W-1:0]  a_q, b_q;
	logic [PREFIX_W-1:0]       pfx_q, idx_q;
	logic                      last_q, en_q;
	logic [DOT_W-1:0]          dot_q;
	logic [NORM_W-1:0]         na_sum_q, nb_sum_q;
	logic [DSQ_W-1:0]          dsq_q;
	logic [RAD_W-1:0]          rad_q;
	logic [31:0]               rem_q;
	logic [ROOT_W-1:0]         root_q, na_q;
	logic [NUM_W-1:0]          num_q;
	logic [DEN_W-1:0]          drem_q;
	logic [QUO_W-1:0]          quo_q;
	logic                      qov_q;
	logic [DIST_W-1:0]         res_q;
	logic                      inf_q;
	logic                      m_valid_q;
	logic [DIST_W-1:0]         m_dist_q;
	logic                      m_inf_q;

	logic                      in_fire, out_free;
	logic signed [ELEM_W:0]    diff;
	mul_req_t                  mreq;
	logic signed [PROD_W-1:0]  prod;
	logic [33:0]               sq_rem_n, sq_trial;
	logic                      sq_ge;
	logic [31:0]               sq_rem_next;
	logic [ROOT_W-1:0]         sq_root_next;
	logic [DEN_W:0]            dv_rem_n, dv_den;
	logic                      dv_ge;
	logic [DEN_W-1:0]          dv_rem_next;
	logic [QUO_W-1:0]          dv_quo_next;
	logic                      dv_qov_next;
	logic [DOT_W-1:0]          dot_mag;
	logic [DIST_W+1:0]         neg_sum;
	logic [DIST_W-1:0]         cos_res;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_dist_q;
	assign m_tuser   = m_inf_q;

	// Operand selection for the shared multiplier.
	assign diff = {a_q[ELEM_W-1], a_q} - {b_q[ELEM_W-1], b_q};
	always_comb begin
		mreq.en = 1'b0;
		mreq.x  = '0;
		mreq.y  = '0;
		if (state_q == ST_MUL) begin
			mreq.en = (cnt_q < CNT_W'(4));
			unique case (cnt_q[1:0])
				2'd0: begin
					mreq.x = MUL_W'(a_q);
					mreq.y = MUL_W'(b_q);
				end
				2'd1: begin
					mreq.x = MUL_W'(a_q);
					mreq.y = MUL_W'(a_q);
				end
				2'd2: begin
					mreq.x = MUL_W'(b_q);
					mreq.y = MUL_W'(b_q);
				end
				default: begin
					mreq.x = MUL_W'(diff);
					mreq.y = MUL_W'(diff);
				end
			endcase
		end else if (state_q == ST_NMUL) begin
			mreq.en = 1'b1;
			mreq.x  = $signed({1'b0, na_q});
			mreq.y  = $signed({1'b0, root_q});
		end
	end

	pvd_mul u_mul (
		.clk  (clk),
		.req  (mreq),
		.prod (prod)
	);

	// One bit pair of the square root per cycle.
	assign sq_rem_n     = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign sq_trial     = {2'b00, root_q, 2'b01};
	assign sq_ge        = (sq_rem_n >= sq_trial);
	assign sq_rem_next  = sq_ge ? 32'(sq_rem_n - sq_trial) : sq_rem_n[31:0];
	assign sq_root_next = {root_q[ROOT_W-2:0], sq_ge};

	// One quotient bit of the long division per cycle.
	assign dv_rem_n    = {drem_q, num_q[NUM_W-1]};
	assign dv_den      = {1'b0, prod[DEN_W-1:0]};
	assign dv_ge       = (dv_rem_n >= dv_den);
	assign dv_rem_next = dv_ge ? DEN_W'(dv_rem_n - dv_den) : dv_rem_n[DEN_W-1:0];
	assign dv_quo_next = {quo_q[QUO_W-2:0], dv_ge};
	assign dv_qov_next = qov_q | quo_q[QUO_W-1];

	// Magnitude of the dot sum and the final cosine result.
	assign dot_mag = dot_q[DOT_W-1] ? (~dot_q + DOT_W'(1)) : dot_q;
	assign neg_sum = (DIST_W+2)'(ONE_Q16) + (DIST_W+2)'(dv_quo_next);
	always_comb begin
		if (dot_q[DOT_W-1]) begin
			cos_res = (dv_qov_next || (neg_sum > (DIST_W+2)'(DIST_MAX)))
			          ? DIST_MAX : neg_sum[DIST_W-1:0];
		end else begin
			cos_res = (dv_qov_next || ((DIST_W+1)'(dv_quo_next) >= (DIST_W+1)'(ONE_Q16)))
			          ? '0 : DIST_W'(ONE_Q16 - dv_quo_next[DIST_W-1:0]);
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid) begin
			mode_q <= cfg_data[0];
		end
	end

	// Input capture.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			a_q    <= s_tdata[15:0];
			b_q    <= s_tdata[31:16];
			pfx_q  <= s_tdata[44:32];
			last_q <= s_tlast;
			en_q   <= (idx_q < s_tdata[44:32]) && (idx_q < MAX_DIM);
		end
	end

	// Sequencer, accumulators and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= SQ_EUCL;
			cnt_q     <= '0;
			idx_q     <= '0;
			dot_q     <= '0;
			na_sum_q  <= '0;
			nb_sum_q  <= '0;
			dsq_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (en_q) begin
						if (cnt_q == CNT_W'(1)) dot_q <= dot_q + prod[DOT_W-1:0];
						if (cnt_q == CNT_W'(2)) na_sum_q <= na_sum_q + prod[NORM_W-1:0];
						if (cnt_q == CNT_W'(3)) nb_sum_q <= nb_sum_q + prod[NORM_W-1:0];
						if (cnt_q == CNT_W'(4)) dsq_q <= dsq_q + prod[DSQ_W-1:0];
					end
					if (cnt_q == MUL_LAST) begin
						cnt_q  <= '0;
						rem_q  <= '0;
						root_q <= '0;
						if (!last_q) begin
							if (idx_q < MAX_DIM) idx_q <= idx_q + PREFIX_W'(1);
							state_q <= ST_IDLE;
						end else if (pfx_q == '0) begin
							res_q   <= DIST_MAX;
							inf_q   <= 1'b1;
							state_q <= ST_FIN;
						end else if (!mode_q) begin
							rad_q   <= RAD_W'({dsq_q, 2'b00});
							phase_q <= SQ_EUCL;
							state_q <= ST_SQRT;
						end else if ((na_sum_q == '0) || (nb_sum_q == '0)) begin
							res_q   <= ONE_Q16;
							inf_q   <= 1'b0;
							state_q <= ST_FIN;
						end else begin
							rad_q   <= RAD_W'({na_sum_q, 16'h0000});
							phase_q <= SQ_NA;
							state_q <= ST_SQRT;
						end
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_SQRT: begin
					if (cnt_q != SQ_LAST) begin
						cnt_q  <= cnt_q + CNT_W'(1);
						rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
						rem_q  <= sq_rem_next;
						root_q <= sq_root_next;
					end else begin
						cnt_q <= '0;
						unique case (phase_q)
							SQ_EUCL: begin
								res_q   <= sq_root_next[DIST_W-1:0];
								inf_q   <= 1'b0;
								state_q <= ST_FIN;
							end
							SQ_NA: begin
								na_q    <= sq_root_next;
								rad_q   <= RAD_W'({nb_sum_q, 16'h0000});
								rem_q   <= '0;
								root_q  <= '0;
								phase_q <= SQ_NB;
							end
							default: begin
								root_q  <= sq_root_next;
								state_q <= ST_NMUL;
							end
						endcase
					end
				end
				ST_NMUL: begin
					num_q   <= {dot_mag, 32'h0000_0000};
					drem_q  <= '0;
					quo_q   <= '0;
					qov_q   <= 1'b0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q  <= cnt_q + CNT_W'(1);
					num_q  <= {num_q[NUM_W-2:0], 1'b0};
					drem_q <= dv_rem_next;
					quo_q  <= dv_quo_next;
					qov_q  <= dv_qov_next;
					if (cnt_q == DIV_LAST) begin
						res_q   <= cos_res;
						inf_q   <= 1'b0;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						m_dist_q  <= res_q;
						m_inf_q   <= inf_q;
						idx_q     <= '0;
						dot_q     <= '0;
						na_sum_q  <= '0;
						nb_sum_q  <= '0;
						dsq_q     <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Checks on the sequencer and the result format.
	`PVD_ASSERT_IMM(a_inf_full_scale, m_tvalid && m_tuser, m_tdata == DIST_MAX, "infinite result without full-scale distance")
	`PVD_ASSERT_IMM(a_index_range, 1'b1, idx_q <= MAX_DIM, "element index beyond maximum dimension")
	`PVD_ASSERT_NXT(a_fin_delivers, (state_q == ST_FIN) && out_free, m_tvalid && (state_q == ST_IDLE), "finished result not moved to output register")

endmodule
